### src/first_free_count_tree_defines.svh
// Assertion macros shared by the checker of the first-free count tree.
// Depends on signals named clk and rst_n in the scope that uses them.
`ifndef FIRST_FREE_COUNT_TREE_DEFINES_SVH
`define FIRST_FREE_COUNT_TREE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/ffct_pkg.sv
// Shared constants, beat types and control structures of the first-free count tree.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package ffct_pkg;

  localparam int DEPTH      = 1024;
  localparam int CNT_W      = 16;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int WORD_W     = 32;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int NUM_WORDS  = DEPTH / WORD_W;
  localparam int WSEL_W     = ADDR_W - BIT_W;
  localparam int SIZE_W     = 11;
  localparam int VALUE_W    = 16;
  localparam int FREE_W     = 10;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(DEPTH);

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [FREE_W-1:0] first_free;
    logic              none_free;
    logic              count_fault;
  } out_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic update;
    logic find;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } stat_t;

endpackage

`default_nettype wire

### src/ffct_ctrl.sv
// Controller of the first-free count tree: clearing pass and per-beat sequence.
// Depends on ffct_pkg for the command and status structures.
`timescale 1ns / 1ps
`default_nettype none

module ffct_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  ffct_pkg::stat_t st,
  output ffct_pkg::cmd_t  cmd
);
  import ffct_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD,
    S_FIND,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_FIND;
      end
      S_FIND: begin
        cmd.find  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### src/ffct_dp.sv
// Datapath of the first-free count tree: count memory, occupancy word memory,
// word summary flags, search logic and the result register. Depends on ffct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffct_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ffct_pkg::cmd_t              cmd,
  output ffct_pkg::stat_t             st,
  input  ffct_pkg::in_t               in_data,
  output ffct_pkg::out_t              out_data,
  input  logic                        cfg_wr_en,
  input  logic [ffct_pkg::SIZE_W-1:0] cfg_wr_data
);
  import ffct_pkg::*;

  logic [CNT_W-1:0]  cnt_mem [DEPTH];
  logic [WORD_W-1:0] flag_mem [NUM_WORDS];

  logic [SIZE_W-1:0]    size_r;
  logic [SIZE_W-1:0]    eff_size;
  logic [ADDR_W-1:0]    clr_addr_r;
  logic                 kind_r;
  logic [ADDR_W-1:0]    value_r;
  logic                 in_range_r;
  logic [CNT_W-1:0]     cnt_rd_r;
  logic [WORD_W-1:0]    flag_rd_r;
  logic [NUM_WORDS-1:0] summary_r;
  logic [WSEL_W-1:0]    srch_word_r;
  logic                 srch_hit_r;
  out_t                 out_r;

  logic [CNT_W-1:0]  cnt_new;
  logic              fault;
  logic [WORD_W-1:0] word_new;
  logic [WSEL_W-1:0] srch_word;
  logic              srch_hit;
  logic [WSEL_W-1:0] flag_raddr;
  logic [WORD_W-1:0] masked;
  logic [BIT_W-1:0]  bit_idx;
  logic              bit_hit;

  assign eff_size    = (size_r > SIZE_MAX) ? SIZE_MAX : size_r;
  assign st.clr_last = (clr_addr_r == {ADDR_W{1'b1}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      size_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r     <= in_data.kind;
      value_r    <= in_data.value[ADDR_W-1:0];
      in_range_r <= (in_data.value < {{(VALUE_W-SIZE_W){1'b0}}, eff_size});
    end
  end

  always_comb begin
    cnt_new = cnt_rd_r;
    fault   = 1'b0;
    if (kind_r == KIND_ADD) begin
      if (cnt_rd_r == {CNT_W{1'b1}}) begin
        fault = 1'b1;
      end else begin
        cnt_new = cnt_rd_r + 1'b1;
      end
    end else begin
      if (cnt_rd_r == '0) begin
        fault = 1'b1;
      end else begin
        cnt_new = cnt_rd_r - 1'b1;
      end
    end
    word_new                     = flag_rd_r;
    word_new[value_r[BIT_W-1:0]] = (cnt_new != '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      cnt_mem[clr_addr_r] <= '0;
    end else if (cmd.update && in_range_r) begin
      cnt_mem[value_r] <= cnt_new;
    end
    if (cmd.accept) begin
      cnt_rd_r <= cnt_mem[in_data.value[ADDR_W-1:0]];
    end
  end

  assign flag_raddr = cmd.accept ? in_data.value[ADDR_W-1:BIT_W] : srch_word;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      flag_mem[clr_addr_r[WSEL_W-1:0]] <= '0;
    end else if (cmd.update && in_range_r) begin
      flag_mem[value_r[ADDR_W-1:BIT_W]] <= word_new;
    end
    if (cmd.accept || cmd.find) begin
      flag_rd_r <= flag_mem[flag_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      summary_r <= '0;
    end else if (cmd.update && in_range_r) begin
      summary_r[value_r[ADDR_W-1:BIT_W]] <= &word_new;
    end
  end

  // The first active word that is not completely occupied holds the answer,
  // unless it is the partly active last word and its active bits are all set.
  always_comb begin
    srch_word = '0;
    srch_hit  = 1'b0;
    for (int w = NUM_WORDS - 1; w >= 0; w--) begin
      if (!summary_r[w] && ({WSEL_W'(w), {BIT_W{1'b0}}} < eff_size)) begin
        srch_word = WSEL_W'(w);
        srch_hit  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find) begin
      srch_word_r <= srch_word;
      srch_hit_r  <= srch_hit;
    end
  end

  always_comb begin
    masked  = flag_rd_r;
    bit_idx = '0;
    bit_hit = 1'b0;
    for (int b = 0; b < WORD_W; b++) begin
      if ({1'b0, srch_word_r, BIT_W'(b)} >= eff_size) begin
        masked[b] = 1'b1;
      end
    end
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!masked[b]) begin
        bit_idx = BIT_W'(b);
        bit_hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r.none_free   <= ~(srch_hit_r & bit_hit);
      out_r.first_free  <= (srch_hit_r & bit_hit) ? FREE_W'({srch_word_r, bit_idx}) : '0;
      out_r.count_fault <= fault & in_range_r;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

### src/first_free_count_tree.sv
// An accepted input beat goes through the update, find and done states; no new input
// beat is taken until its result is loaded, after the count memory read-modify-write
// and the word-level and bit-level find-first-zero steps.
// A result waiting in the output register does not hold off the next input beat.
// Reset is synchronous and active low; a clearing pass then zeroes the count memory
// and the occupancy words, with in_ready low and configuration writes still taken.
`timescale 1ns / 1ps
`default_nettype none

module first_free_count_tree (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ffct_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ffct_pkg::out_t              out_data,
  input  logic                        cfg_wr_en,
  input  logic [ffct_pkg::SIZE_W-1:0] cfg_wr_data
);
  import ffct_pkg::*;

  cmd_t  cmd;
  stat_t st;

  ffct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  ffct_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .in_data     (in_data),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

endmodule

`default_nettype wire

### src/ffct_checker.sv
// Port-level checker of the first-free count tree, bound to the top level.
// Depends on ffct_pkg and on the macros in first_free_count_tree_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "first_free_count_tree_defines.svh"

module ffct_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input ffct_pkg::out_t out_data
);
  import ffct_pkg::*;

  `FFCT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped before it was taken")
  `FFCT_ASSERT_NOW(a_none_zero, out_valid && out_data.none_free, out_data.first_free == '0, "first_free not zero when no slot is free")
  `FFCT_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "input beat accepted while one is being worked on")
  `FFCT_ASSERT_NOW(a_out_from_work, $rose(out_valid), $past(!in_ready), "result beat appeared with no input beat in progress")

endmodule

bind first_free_count_tree ffct_checker u_ffct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

### dv/first_free_count_tree_test.sv
// Self-checking testbench for first_free_count_tree: drives add and remove beats, tracks the
// slot counts and the lowest free slot in its own predictor and checks every result beat.
// Depends on ffct_pkg and the first_free_count_tree RTL only.
`timescale 1ns / 1ps

module first_free_count_tree_test;
  import ffct_pkg::*;

  localparam int CYCLE_LIMIT = 100_000;
  localparam logic [CNT_W-1:0] TALLY_MAX = '1;
  localparam int STACK_SLOT = 600;
  localparam int STACK_DEPTH = 20;
  localparam int FILL_SPAN = 64;
  localparam int BEATS_PER_PHASE = 26;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_t               in_data;
  logic              out_valid;
  logic              out_ready;
  out_t              out_data;
  logic              cfg_wr_en;
  logic [SIZE_W-1:0] cfg_wr_data;

  logic [CNT_W-1:0]  slot_tally [0:DEPTH-1];
  logic [SIZE_W-1:0] active_size_model;
  out_t              expected_results [$];
  bit                idle_on = 1'b1;
  int                beats_sent;
  int                faults_expected;
  int                sizes_written;
  int                mismatches;
  int                cycle_count;

  first_free_count_tree u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("first_free_count_tree_test failed");
      $finish;
    end
  end

  // Applies one beat to the tracked counts and returns the result the block should give.
  function automatic out_t tally_and_find_free(input logic kind, input logic [VALUE_W-1:0] value);
    out_t res;
    int   span;
    bit   hit;
    span = (active_size_model > SIZE_MAX) ? DEPTH : int'(active_size_model);
    res = '0;
    res.none_free = 1'b1;
    if (int'(value) < span) begin
      if (kind == KIND_ADD) begin
        if (slot_tally[value] == TALLY_MAX) res.count_fault = 1'b1;
        else slot_tally[value] = slot_tally[value] + 1'b1;
      end else begin
        if (slot_tally[value] == '0) res.count_fault = 1'b1;
        else slot_tally[value] = slot_tally[value] - 1'b1;
      end
    end
    hit = 1'b0;
    for (int i = 0; i < span && !hit; i++) begin
      if (slot_tally[i] == '0) begin
        res.first_free = i[FREE_W-1:0];
        res.none_free = 1'b0;
        hit = 1'b1;
      end
    end
    if (res.count_fault) faults_expected++;
    return res;
  endfunction

  task automatic send_beat(input logic kind, input logic [VALUE_W-1:0] value);
    in_t beat;
    int  gap;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat.kind = kind;
    beat.value = value;
    in_data <= beat;
    in_valid <= 1'b1;
    expected_results.push_back(tally_and_find_free(kind, value));
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_active_size(input logic [SIZE_W-1:0] size);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= size;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    active_size_model = size;
    sizes_written++;
  endtask

  task automatic test_directed_edges;
    set_active_size(SIZE_RESET);
    send_beat(KIND_ADD, 16'd0);
    send_beat(KIND_ADD, 16'd0);
    send_beat(KIND_REMOVE, 16'd0);
    send_beat(KIND_REMOVE, 16'd0);
    send_beat(KIND_REMOVE, 16'd0);
    send_beat(KIND_ADD, 16'd1023);
    send_beat(KIND_ADD, 16'd1024);
    send_beat(KIND_ADD, 16'hFFFF);
    send_beat(KIND_ADD, 16'h5555);
    send_beat(KIND_REMOVE, 16'hAAAA);
    send_beat(KIND_REMOVE, 16'd1023);
    send_beat(KIND_REMOVE, 16'd1023);
    set_active_size('0);
    send_beat(KIND_ADD, 16'd0);
    send_beat(KIND_REMOVE, 16'd5);
    set_active_size(SIZE_W'(1));
    send_beat(KIND_ADD, 16'd0);
    send_beat(KIND_ADD, 16'd1);
    send_beat(KIND_REMOVE, 16'd0);
    set_active_size('1);
    send_beat(KIND_ADD, 16'd1023);
    send_beat(KIND_ADD, 16'd1024);
    send_beat(KIND_ADD, 16'd2046);
    send_beat(KIND_REMOVE, 16'd1023);
  endtask

  // Back-to-back beats stack up one slot's count and then drain it past zero.
  task automatic test_back_to_back_stack;
    set_active_size(SIZE_RESET);
    idle_on = 1'b0;
    repeat (STACK_DEPTH) send_beat(KIND_ADD, VALUE_W'(STACK_SLOT));
    repeat (STACK_DEPTH + 2) send_beat(KIND_REMOVE, VALUE_W'(STACK_SLOT));
    idle_on = 1'b1;
  endtask

  task automatic test_fill_and_empty;
    set_active_size(SIZE_W'(FILL_SPAN));
    for (int i = 0; i < FILL_SPAN; i++) send_beat(KIND_ADD, VALUE_W'(i));
    for (int i = FILL_SPAN - 1; i >= 0; i--) send_beat(KIND_REMOVE, VALUE_W'(i));
  endtask

  task automatic test_random_mix;
    int          phase_sizes [10];
    int          span;
    int          low_span;
    int          add_pct;
    int          pick;
    logic        kind;
    logic [VALUE_W-1:0] value;
    phase_sizes = '{3, 8, 17, 33, 64, 200, 1024, 2047, 5, 0};
    phase_sizes[9] = $urandom_range(1, 2047);
    for (int p = 0; p < 10; p++) begin
      set_active_size(SIZE_W'(phase_sizes[p]));
      idle_on = (p != 4);
      span = (phase_sizes[p] > DEPTH) ? DEPTH : phase_sizes[p];
      low_span = (span > 48) ? 48 : span;
      add_pct = $urandom_range(50, 80);
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        kind = ($urandom_range(0, 99) < add_pct) ? KIND_ADD : KIND_REMOVE;
        pick = $urandom_range(0, 9);
        if (pick < 6) value = VALUE_W'($urandom_range(0, low_span - 1));
        else if (pick < 7) value = VALUE_W'($urandom());
        else if (pick < 8) value = VALUE_W'(phase_sizes[p] + $urandom_range(0, 4) - 2);
        else value = VALUE_W'($urandom_range(0, span - 1));
        send_beat(kind, value);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    out_t expected;
    int   stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Result beat with nothing expected: %p", out_data);
        end else begin
          expected = expected_results.pop_front();
          if (out_data.first_free !== expected.first_free ||
              out_data.none_free !== expected.none_free ||
              out_data.count_fault !== expected.count_fault) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: expected first_free %0d none_free %0b count_fault %0b,",
                       expected.first_free, expected.none_free, expected.count_fault);
              $display("          actual   first_free %0d none_free %0b count_fault %0b",
                       out_data.first_free, out_data.none_free, out_data.count_fault);
            end
          end
        end
        stall = idle_on ? $urandom_range(0, 12) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) slot_tally[i] = '0;
    active_size_model = SIZE_RESET;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    cycle_count <= 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_back_to_back_stack();
    test_fill_and_empty();
    test_random_mix();
    drain_results();
    $display("Covered %0d beats under %0d active_size settings, %0d with a count fault.",
             beats_sent, sizes_written, faults_expected);
    $display("Mismatches: %0d, results still outstanding: %0d.",
             mismatches, expected_results.size());
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("first_free_count_tree_test passed");
    end else begin
      $display("first_free_count_tree_test failed");
    end
    $finish;
  end

endmodule

### first_free_count_tree.f
+incdir+src
src/ffct_pkg.sv
src/ffct_ctrl.sv
src/ffct_dp.sv
src/first_free_count_tree.sv
src/ffct_checker.sv
dv/first_free_count_tree_test.sv
